// ----- src/endpoint_id_allocator_defines.svh -----
// assertion macros used by the endpoint allocator module
`ifndef ENDPOINT_ID_ALLOCATOR_DEFINES_SVH
`define ENDPOINT_ID_ALLOCATOR_DEFINES_SVH

// condition must hold on every clock outside reset
`define EPA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define EPA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define EPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/epa_pkg.sv -----
// shared widths, codes and defaults of the endpoint allocator
package epa_pkg;

   localparam int EP_WIDTH        = 6;
   localparam int STATUS_WIDTH    = 2;
   localparam int ENTRIES_DEFAULT = 64;

   // command codes of a request beat
   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // result status codes
   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK     = 2'd0,
      ST_BAD_EP = 2'd1,
      ST_NO_EP  = 2'd2
   } status_type;

endpackage

// ----- src/epa_channels.sv -----
// valid/ready channels for request and response beats

interface epa_req_if;
   logic                         valid;
   logic                         ready;
   logic                         cmd;
   logic [epa_pkg::EP_WIDTH-1:0] endpoint;
   logic                         is_line;

   modport source (output valid, cmd, endpoint, is_line, input ready);
   modport sink   (input valid, cmd, endpoint, is_line, output ready);
endinterface

interface epa_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [epa_pkg::STATUS_WIDTH-1:0] status;
   logic [epa_pkg::EP_WIDTH-1:0]     endpoint_out;

   modport source (output valid, status, endpoint_out, input ready);
   modport sink   (input valid, status, endpoint_out, output ready);
endinterface

// ----- src/endpoint_id_allocator.sv -----
// endpoint allocator: doubly linked free and line lists over link memories
// steps: a request is read and checked; a rejected one goes on to the done step, a plain
// allocate through unlink, a plain release through link and tail, and a line allocate or
// release through unlink, link and tail; a new request is taken only in the idle step,
// also while a response waits. reset: synchronous; a clearing pass over every entry then
// initializes the link memories and no request is taken until it ends
`include "endpoint_id_allocator_defines.svh"

module endpoint_id_allocator #(
   parameter int ENTRIES = epa_pkg::ENTRIES_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   epa_req_if.sink    req_ch,
   epa_rsp_if.source  rsp_ch
);

   localparam int EW      = epa_pkg::EP_WIDTH;
   localparam int LW      = $clog2(ENTRIES);
   localparam int EP_SPAN = 2 ** EW;
   localparam logic [LW-1:0] LAST = LW'(ENTRIES - 1);
   localparam logic          EP_CAN_EXCEED = (ENTRIES < EP_SPAN);
   localparam logic [EW-1:0] EP_LIMIT = EW'((ENTRIES < EP_SPAN) ? ENTRIES : 0);

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_READ   = 8'b0000_0100,
      S_CHECK  = 8'b0000_1000,
      S_UNLINK = 8'b0001_0000,
      S_LINK   = 8'b0010_0000,
      S_TAIL   = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // link and flag memories, flags are {in_use, line_mark}
   logic [LW-1:0] next_mem [ENTRIES];
   logic [LW-1:0] prev_mem [ENTRIES];
   logic [1:0]    flag_mem [ENTRIES];

   logic          nxt_we, prv_we, flg_we;
   logic [LW-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd, flg_wa;
   logic [1:0]    flg_wd;
   logic [LW-1:0] nxt_ra, ep_addr;
   logic [LW-1:0] next_rd_ff, prev_rd_ff;
   logic [1:0]    flag_rd_ff;

   logic [LW-1:0] clr_ff, clr_in;
   logic [LW-1:0] free_head_ff, free_head_in, free_tail_ff, free_tail_in;
   logic [LW-1:0] line_head_ff, line_head_in, line_tail_ff, line_tail_in;

   // captured request and working links
   logic          cmd_ff, line_ff;
   logic [EW-1:0] ep_ff;
   logic [LW-1:0] tgt_ff, tgt_in, p_ff, p_in, n_ff, n_in;

   // result held until the output register is free
   epa_pkg::status_type status_ff, status_in, rsp_status_ff;
   logic [EW-1:0]       res_ep_ff, res_ep_in, rsp_ep_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   logic          req_beat, load_rsp, in_range, is_any;
   logic [LW-1:0] tgt_sel;
   logic [EW+LW-1:0] ep_wide, tgt_wide, lhead_wide;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_beat     = req_ch.valid && req_ch.ready;

   assign ep_wide  = {{LW{1'b0}}, ep_ff};
   assign ep_addr  = ep_wide[LW-1:0];
   assign in_range = !(EP_CAN_EXCEED && (ep_ff >= EP_LIMIT));
   assign is_any   = (ep_ff == '0);
   assign tgt_sel  = is_any ? free_head_ff : ep_addr;
   assign tgt_wide   = {{EW{1'b0}}, tgt_sel};
   assign lhead_wide = {{EW{1'b0}}, line_head_ff};

   assign nxt_ra = (cmd_ff == epa_pkg::CMD_ALLOC && is_any) ? free_head_ff : ep_addr;

   assign load_rsp = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   // sequencer and memory write ports
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      free_head_in = free_head_ff;
      free_tail_in = free_tail_ff;
      line_head_in = line_head_ff;
      line_tail_in = line_tail_ff;
      tgt_in       = tgt_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      status_in    = status_ff;
      res_ep_in    = res_ep_ff;
      nxt_we = 1'b0;  nxt_wa = tgt_ff;  nxt_wd = '0;
      prv_we = 1'b0;  prv_wa = tgt_ff;  prv_wd = '0;
      flg_we = 1'b0;  flg_wa = tgt_ff;  flg_wd = '0;
      case (state_ff)
         S_CLEAR: begin
            nxt_we = 1'b1;  nxt_wa = clr_ff;
            prv_we = 1'b1;  prv_wa = clr_ff;
            flg_we = 1'b1;  flg_wa = clr_ff;
            nxt_wd = (clr_ff == '0 || clr_ff == LAST) ? '0 : clr_ff + LW'(1);
            prv_wd = (clr_ff == '0) ? '0 : clr_ff - LW'(1);
            clr_in = clr_ff + LW'(1);
            if (clr_ff == LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_beat) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            res_ep_in = ep_ff;
            if (cmd_ff == epa_pkg::CMD_ALLOC) begin
               if (!in_range || flag_rd_ff[1]) begin
                  status_in = epa_pkg::ST_BAD_EP;
                  state_in  = S_DONE;
               end else if (free_head_ff == '0) begin
                  status_in = epa_pkg::ST_NO_EP;
                  res_ep_in = lhead_wide[EW-1:0];
                  state_in  = S_DONE;
               end else begin
                  status_in = epa_pkg::ST_OK;
                  res_ep_in = tgt_wide[EW-1:0];
                  tgt_in    = tgt_sel;
                  p_in      = is_any ? '0 : prev_rd_ff;
                  n_in      = next_rd_ff;
                  state_in  = S_UNLINK;
               end
            end else begin
               if (is_any || !in_range || !flag_rd_ff[1]) begin
                  status_in = epa_pkg::ST_BAD_EP;
                  state_in  = S_DONE;
               end else begin
                  status_in = epa_pkg::ST_OK;
                  tgt_in    = ep_addr;
                  p_in      = prev_rd_ff;
                  n_in      = next_rd_ff;
                  state_in  = flag_rd_ff[0] ? S_UNLINK : S_LINK;
               end
            end
         end
         S_UNLINK: begin
            // bypass the entry: predecessor to successor and back
            if (p_ff == '0) begin
               if (cmd_ff == epa_pkg::CMD_ALLOC) free_head_in = n_ff;
               else                               line_head_in = n_ff;
            end else begin
               nxt_we = 1'b1;  nxt_wa = p_ff;  nxt_wd = n_ff;
            end
            if (n_ff == '0) begin
               if (cmd_ff == epa_pkg::CMD_ALLOC) free_tail_in = p_ff;
               else                               line_tail_in = p_ff;
            end else begin
               prv_we = 1'b1;  prv_wa = n_ff;  prv_wd = p_ff;
            end
            if (cmd_ff == epa_pkg::CMD_ALLOC) begin
               flg_we   = 1'b1;
               flg_wd   = {1'b1, line_ff};
               state_in = line_ff ? S_LINK : S_DONE;
            end else begin
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            if (cmd_ff == epa_pkg::CMD_ALLOC) begin
               // append to the line list
               if (line_tail_ff == '0) begin
                  line_head_in = tgt_ff;
               end else begin
                  nxt_we = 1'b1;  nxt_wa = line_tail_ff;  nxt_wd = tgt_ff;
               end
               prv_we       = 1'b1;
               prv_wd       = line_tail_ff;
               line_tail_in = tgt_ff;
            end else begin
               // entry becomes the new free tail
               nxt_we = 1'b1;
               prv_we = 1'b1;
               prv_wd = free_tail_ff;
               flg_we = 1'b1;
            end
            state_in = S_TAIL;
         end
         S_TAIL: begin
            if (cmd_ff == epa_pkg::CMD_ALLOC) begin
               nxt_we = 1'b1;
            end else begin
               if (free_tail_ff == '0) begin
                  free_head_in = tgt_ff;
               end else begin
                  nxt_we = 1'b1;  nxt_wa = free_tail_ff;  nxt_wd = tgt_ff;
               end
               free_tail_in = tgt_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response valid: set on load, cleared when the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         free_head_ff <= LW'(1);
         free_tail_ff <= LAST;
         line_head_ff <= '0;
         line_tail_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_head_ff <= free_head_in;
         free_tail_ff <= free_tail_in;
         line_head_ff <= line_head_in;
         line_tail_ff <= line_tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         cmd_ff  <= req_ch.cmd;
         ep_ff   <= req_ch.endpoint;
         line_ff <= req_ch.is_line;
      end
      tgt_ff    <= tgt_in;
      p_ff      <= p_in;
      n_ff      <= n_in;
      status_ff <= status_in;
      res_ep_ff <= res_ep_in;
      if (load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_ep_ff     <= res_ep_ff;
      end
   end

   // link memories with registered reads
   always_ff @(posedge clock) begin
      if (nxt_we) begin
         next_mem[nxt_wa] <= nxt_wd;
      end
      next_rd_ff <= next_mem[nxt_ra];
   end

   always_ff @(posedge clock) begin
      if (prv_we) begin
         prev_mem[prv_wa] <= prv_wd;
      end
      prev_rd_ff <= prev_mem[ep_addr];
   end

   always_ff @(posedge clock) begin
      if (flg_we) begin
         flag_mem[flg_wa] <= flg_wd;
      end
      flag_rd_ff <= flag_mem[ep_addr];
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.endpoint_out = rsp_ep_ff;

   // checks
   `EPA_ASSERT_NEXT(a_accept_reads, clock, reset, req_beat, state_ff == S_READ,
      "accepted beat did not start a lookup")
   `EPA_ASSERT_IMPLIES(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == S_DONE, "response raised outside done step")
   `EPA_ASSERT_ALWAYS(a_free_ends, clock, reset,
      (free_head_ff == '0) == (free_tail_ff == '0), "free list head and tail disagree on empty")
   `EPA_ASSERT_ALWAYS(a_line_ends, clock, reset,
      (line_head_ff == '0) == (line_tail_ff == '0), "line list head and tail disagree on empty")

endmodule

// ----- test/tb.sv -----
// testbench for the endpoint allocator: table predictor, checker and handshake drivers
`timescale 1ns / 100ps

// mirror of the endpoint table and the queue of responses still owed by the block
class ep_ledger;
   localparam int SLOTS = epa_pkg::ENTRIES_DEFAULT;
   localparam int EW    = epa_pkg::EP_WIDTH;

   typedef struct {
      epa_pkg::status_type status;
      logic [EW-1:0]       ep;
   } grant_type;

   bit                          in_use[SLOTS];
   bit                          line_mark[SLOTS];
   bit [EW-1:0]                 fwd[SLOTS];
   bit [EW-1:0]                 back[SLOTS];
   bit [EW-1:0]                 free_head, free_tail, line_head, line_tail;
   grant_type                   awaited_grants[$];
   int                          errors;

   function new();
      for (int i = 0; i < SLOTS; i++) begin
         in_use[i]    = 1'b0;
         line_mark[i] = 1'b0;
         fwd[i]       = EW'((i + 1 < SLOTS) ? i + 1 : 0);
         back[i]      = EW'((i == 0) ? 0 : i - 1);
      end
      fwd[0]    = '0;
      free_head = EW'(1);
      free_tail = EW'(SLOTS - 1);
      line_head = '0;
      line_tail = '0;
      errors    = 0;
   endfunction

   function int pending();
      return awaited_grants.size();
   endfunction

   // random free entry, 0 when the free list is empty
   function int pick_free();
      int start;
      int e;
      start = $urandom_range(1, SLOTS - 1);
      for (int k = 0; k < SLOTS - 1; k++) begin
         e = 1 + (start - 1 + k) % (SLOTS - 1);
         if (!in_use[e]) return e;
      end
      return 0;
   endfunction

   // random entry in use, 0 when none is
   function int pick_busy();
      int start;
      int e;
      start = $urandom_range(1, SLOTS - 1);
      for (int k = 0; k < SLOTS - 1; k++) begin
         e = 1 + (start - 1 + k) % (SLOTS - 1);
         if (in_use[e]) return e;
      end
      return 0;
   endfunction

   // apply one accepted request to the table and queue the response it owes
   function void note_request(logic cmd, logic [EW-1:0] ep, logic line);
      grant_type   g;
      bit [EW-1:0] e, p, n;
      e        = ep;
      g.ep     = e;
      g.status = epa_pkg::ST_BAD_EP;
      if (cmd == epa_pkg::CMD_ALLOC) begin
         if (int'(e) >= SLOTS || in_use[e]) begin
            g.status = epa_pkg::ST_BAD_EP;
         end else if (free_head == '0) begin
            g.status = epa_pkg::ST_NO_EP;
            g.ep     = line_head;
         end else begin
            // take from the head, or unlink from anywhere in the free list
            if (e == '0) begin
               e         = free_head;
               free_head = fwd[e];
               if (free_head == '0) free_tail = '0;
               else back[free_head] = '0;
            end else begin
               p = back[e];
               n = fwd[e];
               if (p == '0) free_head = n;
               else fwd[p] = n;
               if (n == '0) free_tail = p;
               else back[n] = p;
            end
            // line entries go on the tail of the line list
            if (line) begin
               if (line_tail == '0) line_head = e;
               else fwd[line_tail] = e;
               back[e]   = line_tail;
               fwd[e]    = '0;
               line_tail = e;
            end
            in_use[e]    = 1'b1;
            line_mark[e] = line;
            g.status     = epa_pkg::ST_OK;
            g.ep         = e;
         end
      end else if (e != '0 && int'(e) < SLOTS && in_use[e]) begin
         // unlink from the line list, then append to the free tail
         if (line_mark[e]) begin
            p = back[e];
            n = fwd[e];
            if (p == '0) line_head = n;
            else fwd[p] = n;
            if (n == '0) line_tail = p;
            else back[n] = p;
         end
         fwd[e]  = '0;
         back[e] = free_tail;
         if (free_tail == '0) free_head = e;
         else fwd[free_tail] = e;
         free_tail    = e;
         in_use[e]    = 1'b0;
         line_mark[e] = 1'b0;
         g.status     = epa_pkg::ST_OK;
      end
      awaited_grants.push_back(g);
   endfunction

   function void flag(string what);
      errors++;
      if (errors <= 10) $display("mismatch: %s", what);
   endfunction

   // compare one response beat with the oldest owed response
   function void check_response(logic [epa_pkg::STATUS_WIDTH-1:0] status,
                                logic [EW-1:0] ep_out);
      grant_type g;
      if (awaited_grants.size() == 0) begin
         flag($sformatf("unexpected response status %0d endpoint %0d", status, ep_out));
         return;
      end
      g = awaited_grants.pop_front();
      if (status !== g.status || ep_out !== g.ep)
         flag($sformatf("expected status %0d endpoint %0d, got status %0d endpoint %0d",
                        g.status, g.ep, status, ep_out));
   endfunction
endclass

module tb;

   localparam int EW          = epa_pkg::EP_WIDTH;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_ITEMS = 278;

   logic clock;
   logic reset;

   epa_req_if req_if ();
   epa_rsp_if rsp_if ();

   ep_ledger ledger;

   int req_idle_pct;
   int rsp_idle_pct;
   int stall_cycles;

   endpoint_id_allocator #(.ENTRIES(epa_pkg::ENTRIES_DEFAULT)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // response backpressure
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // response check
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         ledger.check_response(rsp_if.status, rsp_if.endpoint_out);
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // present one request beat, entered and left just after a falling edge
   task automatic push_request(logic cmd, logic [EW-1:0] ep, logic line);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.cmd      <= cmd;
      req_if.endpoint <= ep;
      req_if.is_line  <= line;
      do @(posedge clock); while (!req_if.ready);
      ledger.note_request(cmd, ep, line);
      @(negedge clock);
   endtask

   // hold off requests until every owed response has come back
   task automatic drain_responses();
      req_if.valid <= 1'b0;
      while (ledger.pending() > 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // random request, mostly useful ones with some noise
   task automatic push_random(int alloc_pct);
      int            pick;
      logic [EW-1:0] ep;
      pick = $urandom_range(99);
      if ($urandom_range(99) < alloc_pct) begin
         if (pick < 30) ep = '0;
         else if (pick < 85) ep = EW'(ledger.pick_free());
         else ep = EW'($urandom_range(0, 63));
         push_request(epa_pkg::CMD_ALLOC, ep, 1'($urandom_range(1)));
      end else begin
         if (pick < 80) ep = EW'(ledger.pick_busy());
         else ep = EW'($urandom_range(0, 63));
         push_request(epa_pkg::CMD_RELEASE, ep, 1'($urandom_range(1)));
      end
   endtask

   // random phase: filling the table first, then emptying it
   task automatic run_phase(int send_idle, int recv_idle);
      req_idle_pct = send_idle;
      rsp_idle_pct = recv_idle;
      for (int i = 0; i < PHASE_ITEMS; i++)
         push_random((i < PHASE_ITEMS / 2) ? 85 : 25);
      drain_responses();
   endtask

   initial begin
      ledger          = new();
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.cmd      = epa_pkg::CMD_ALLOC;
      req_if.endpoint = '0;
      req_if.is_line  = 1'b0;
      rsp_if.ready    = 1'b0;
      req_idle_pct    = 30;
      rsp_idle_pct    = 75;
      stall_cycles    = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: head takes, middle and tail takes, line list ends, bad requests
      push_request(epa_pkg::CMD_ALLOC,   6'd0,  1'b0);
      push_request(epa_pkg::CMD_ALLOC,   6'd0,  1'b1);
      push_request(epa_pkg::CMD_ALLOC,   6'd63, 1'b1);
      push_request(epa_pkg::CMD_ALLOC,   6'd32, 1'b0);
      push_request(epa_pkg::CMD_ALLOC,   6'd32, 1'b1);
      push_request(epa_pkg::CMD_ALLOC,   6'd3,  1'b1);
      push_request(epa_pkg::CMD_RELEASE, 6'd0,  1'b0);
      push_request(epa_pkg::CMD_RELEASE, 6'd40, 1'b1);
      push_request(epa_pkg::CMD_RELEASE, 6'd63, 1'b0);
      push_request(epa_pkg::CMD_RELEASE, 6'd2,  1'b1);
      push_request(epa_pkg::CMD_RELEASE, 6'd32, 1'b0);
      push_request(epa_pkg::CMD_RELEASE, 6'd1,  1'b0);
      push_request(epa_pkg::CMD_ALLOC,   6'd0,  1'b1);
      push_request(epa_pkg::CMD_ALLOC,   6'd63, 1'b1);
      push_request(epa_pkg::CMD_ALLOC,   6'd1,  1'b0);
      push_request(epa_pkg::CMD_RELEASE, 6'd63, 1'b0);
      push_request(epa_pkg::CMD_RELEASE, 6'd3,  1'b1);
      push_request(epa_pkg::CMD_ALLOC,   6'd4,  1'b0);
      drain_responses();

      run_phase(30, 75);
      run_phase(75, 30);
      run_phase(0, 0);

      // all requests sent: wait out the last responses
      while (ledger.pending() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (ledger.errors == 0 && ledger.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
